[rtl/sn3_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sn3_pkg
// Constants, permutation ROM and helper functions for the 3D simplex noise
// pipeline.
// ----------------------------------------------------------------------------
package sn3_pkg;

  // Fractional bits of the input coordinates.
  localparam int FRAC_BITS = 16;
  localparam int PERM_SIZE = 256;

  // Offset width: offsets are kept modulo 2^OFS_W in units of 2^-FRAC_BITS/6.
  localparam int OFS_W = FRAC_BITS + 8;

  // Skew stage: (4x+y+z) >>> FRAC_BITS, biased positive, divided by 3.
  localparam int SKQ_W = 35 - FRAC_BITS;
  localparam int SKU_W = SKQ_W + 2;
  localparam int SKN   = SKU_W + 2;
  localparam longint SKR = ((longint'(1) << SKN) + 2) / 3;
  localparam logic [SKN-1:0] SK_RCP  = SKN'(SKR);
  localparam logic [SKU_W-1:0] SK_BIAS = SKU_W'(longint'(3) << (SKQ_W - 1));

  // Corner stage: offset biased positive, divided by 3.
  localparam int COU_W = OFS_W + 2;
  localparam int CON   = COU_W + 2;
  localparam longint COR = ((longint'(1) << CON) + 2) / 3;
  localparam logic [CON-1:0] CO_RCP  = CON'(COR);
  localparam logic [COU_W-1:0] CO_BIAS = COU_W'(longint'(3) << (OFS_W - 1));

  // Q.28 conversion: q = floor(e * 2^SCL / 3).
  localparam int SCL  = 27 - FRAC_BITS;
  localparam int Q_W  = 32;
  localparam logic [Q_W-1:0] REM1 = Q_W'((longint'(1) << SCL) / 3);
  localparam logic [Q_W-1:0] REM2 = Q_W'((longint'(2) << SCL) / 3);

  // 0.6 in Q.28.
  localparam logic [35:0] FALLOFF = 36'd161061274;

  localparam int OUT_W = 18;
  localparam logic signed [25:0] OUT_MAX = 26'sd131071;
  localparam logic signed [25:0] OUT_MIN = -26'sd131072;

  localparam logic [7:0] PERM [PERM_SIZE] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  // Gradient index = hash mod 12, as {(hash>>2) mod 3, hash[1:0]}.
  function automatic logic [3:0] grad_idx(input logic [7:0] h);
    logic [5:0]  a;
    logic [12:0] p;
    logic [5:0]  qt;
    logic [5:0]  m;
    a  = h[7:2];
    p  = 13'(a) * 13'd43;
    qt = 6'(p >> 7);
    m  = a - 6'(qt * 6'd3);
    return {m[1:0], h[1:0]};
  endfunction

endpackage
`default_nettype wire

[rtl/simplex_noise_3d.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// simplex_noise_3d
// Fixed-point 3D simplex noise: one point in, one saturated noise beat out.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input beat is captured in stage 1 and its result is loaded
// into the output register in stage 14 (14 register stages).
// Throughput: one beat per cycle; the 14-stage pipeline advances as a whole
// and holds only while the output beat is stalled.
// Reset: rst (synchronous) clears the stage valid bits and the seed register.
// ----------------------------------------------------------------------------
module simplex_noise_3d (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                seed_wr_en,
  input  wire logic [31:0]         seed_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [31:0]  coord_x,
  input  wire logic signed [31:0]  coord_y,
  input  wire logic signed [31:0]  coord_z,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [17:0]       noise_value
);

  localparam int AW = sn3_pkg::OFS_W;
  localparam int F  = sn3_pkg::FRAC_BITS;
  localparam int UW = sn3_pkg::SKU_W;
  localparam int N1 = sn3_pkg::SKN;
  localparam int CW = sn3_pkg::COU_W;
  localparam int N2 = sn3_pkg::CON;
  localparam int QW = sn3_pkg::Q_W;

  // Seed register and permutation mask (XOR of the seed's bytes).
  logic [31:0] seed;
  logic [7:0]  mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (seed_wr_en) begin
      seed <= seed_wr_data;
    end
  end

  assign mask = seed[7:0] ^ seed[15:8] ^ seed[23:16] ^ seed[31:24];

  // Whole pipeline advances unless the output beat is held.
  logic        en;
  logic [14:1] v;

  assign en        = !(v[14] && out_stall);
  assign in_stall  = !en;
  assign out_valid = v[14];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[13:1], in_valid};
    end
  end

  // Stage 1: capture the point.
  logic signed [31:0] x1, y1, z1;

  // Stage 2: skewed sums, floored by 2^F and biased positive.
  logic signed [34:0] sx, sy, sz;
  logic [UW-1:0]      ux2, uy2, uz2;
  logic [AW-1:0]      x2, y2, z2;

  assign sx = (35'(x1) <<< 2) + 35'(y1) + 35'(z1);
  assign sy = 35'(x1) + (35'(y1) <<< 2) + 35'(z1);
  assign sz = 35'(x1) + 35'(y1) + (35'(z1) <<< 2);

  // Stage 3: reciprocal products for the divide by 3.
  logic [UW+N1-1:0] px3, py3, pz3;
  logic [AW-1:0]    x3, y3, z3;

  // Stage 4: offsets from the cell origin and simplex order.
  logic [7:0]    ci, cj, ck, csum, wx, wy, wz;
  logic [AW-1:0] axc, ayc, azc;
  logic [2:0]    o1c, o2c;
  logic [AW-1:0] ax4, ay4, az4;
  logic [7:0]    i4, j4, k4;
  logic [2:0]    o14, o24;

  assign ci   = px3[N1 +: 8];
  assign cj   = py3[N1 +: 8];
  assign ck   = pz3[N1 +: 8];
  assign csum = ci + cj + ck;
  assign wx   = csum - 8'(ci * 8'd6);
  assign wy   = csum - 8'(cj * 8'd6);
  assign wz   = csum - 8'(ck * 8'd6);
  assign axc  = AW'(x3 * AW'(6)) + (AW'(wx) << F);
  assign ayc  = AW'(y3 * AW'(6)) + (AW'(wy) << F);
  assign azc  = AW'(z3 * AW'(6)) + (AW'(wz) << F);

  // Corner order bits {i,j,k}; ties resolve toward x over y over z.
  always_comb begin
    if ($signed(axc) >= $signed(ayc)) begin
      if ($signed(ayc) >= $signed(azc)) begin
        o1c = 3'b100; o2c = 3'b110;
      end else if ($signed(axc) >= $signed(azc)) begin
        o1c = 3'b100; o2c = 3'b101;
      end else begin
        o1c = 3'b001; o2c = 3'b101;
      end
    end else begin
      if ($signed(ayc) < $signed(azc)) begin
        o1c = 3'b001; o2c = 3'b011;
      end else if ($signed(axc) < $signed(azc)) begin
        o1c = 3'b010; o2c = 3'b011;
      end else begin
        o1c = 3'b010; o2c = 3'b110;
      end
    end
  end

  // Stage 5: corner offsets and the first hash level.
  logic [3:0]    oi4, oj4, ok4;
  logic [AW-1:0] ec [4][3];
  logic [7:0]    hkc [4];
  logic [AW-1:0] e5 [4][3];
  logic [7:0]    hk5 [4];
  logic [7:0]    i5, j5;
  logic [3:0]    oi5, oj5;

  assign oi4 = {1'b1, o24[2], o14[2], 1'b0};
  assign oj4 = {1'b1, o24[1], o14[1], 1'b0};
  assign ok4 = {1'b1, o24[0], o14[0], 1'b0};

  always_comb begin
    ec[0][0] = ax4;
    ec[0][1] = ay4;
    ec[0][2] = az4;
    ec[1][0] = ax4 + (o14[2] ? AW'(-5 * (1 << F)) : AW'(1 << F));
    ec[1][1] = ay4 + (o14[1] ? AW'(-5 * (1 << F)) : AW'(1 << F));
    ec[1][2] = az4 + (o14[0] ? AW'(-5 * (1 << F)) : AW'(1 << F));
    ec[2][0] = ax4 + (o24[2] ? AW'(-4 * (1 << F)) : AW'(2 << F));
    ec[2][1] = ay4 + (o24[1] ? AW'(-4 * (1 << F)) : AW'(2 << F));
    ec[2][2] = az4 + (o24[0] ? AW'(-4 * (1 << F)) : AW'(2 << F));
    ec[3][0] = ax4 - AW'(3 << F);
    ec[3][1] = ay4 - AW'(3 << F);
    ec[3][2] = az4 - AW'(3 << F);
    for (int c = 0; c < 4; c++) begin
      hkc[c] = sn3_pkg::PERM[k4 + 8'(ok4[c])] ^ mask;
    end
  end

  // Stage 6: second hash level, offsets biased positive.
  logic [7:0]    hjc [4];
  logic [CW-1:0] uec [4][3];
  logic [7:0]    hj6 [4];
  logic [CW-1:0] ue6 [4][3];
  logic [AW-1:0] e6 [4][3];
  logic [7:0]    i6;
  logic [3:0]    oi6;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hjc[c] = sn3_pkg::PERM[j5 + 8'(oj5[c]) + hk5[c]] ^ mask;
      for (int d = 0; d < 3; d++) begin
        uec[c][d] = CW'($signed(e5[c][d])) + sn3_pkg::CO_BIAS;
      end
    end
  end

  // Stage 7: gradient index and reciprocal products.
  logic [3:0]       gc [4];
  logic [3:0]       g7 [4];
  logic [CW+N2-1:0] pe7 [4][3];
  logic [AW-1:0]    e7 [4][3];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      gc[c] = sn3_pkg::grad_idx(sn3_pkg::PERM[i6 + 8'(oi6[c]) + hj6[c]] ^ mask);
    end
  end

  // Stage 8: offsets in Q.28, q = floor(e * 2^SCL / 3).
  logic [AW-1:0]        ac [4][3];
  logic [AW-1:0]        rc [4][3];
  logic signed [QW-1:0] qc [4][3];
  logic signed [QW-1:0] q8 [4][3];
  logic [3:0]           g8 [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int d = 0; d < 3; d++) begin
        // Quotient is a + 2^(AW-1); flip the top bit to drop the bias.
        ac[c][d] = pe7[c][d][N2 +: AW] ^ (AW'(1) << (AW - 1));
        rc[c][d] = e7[c][d] - AW'(ac[c][d] * AW'(3));
        qc[c][d] = (QW'($signed(ac[c][d])) <<< sn3_pkg::SCL)
                 + (rc[c][d][1] ? sn3_pkg::REM2 :
                    rc[c][d][0] ? sn3_pkg::REM1 : '0);
      end
    end
  end

  // Stage 9: squares.
  logic [63:0]          sq9 [4][3];
  logic signed [QW-1:0] q9 [4][3];
  logic [3:0]           g9 [4];

  // Stage 10: falloff and gradient dot product.
  logic [63:0]        d2s [4];
  logic [35:0]        d2c [4];
  logic [27:0]        tc [4];
  logic signed [QW:0] uc [4], wc [4];
  logic signed [29:0] dc [4];
  logic [27:0]        t10 [4];
  logic signed [29:0] dot10 [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      d2s[c] = sq9[c][0] + sq9[c][1] + sq9[c][2];
      d2c[c] = 36'(d2s[c] >> 28);
      // Drop corners outside the falloff radius: zero t zeroes the term.
      tc[c]  = (d2c[c] < sn3_pkg::FALLOFF) ? 28'(sn3_pkg::FALLOFF - d2c[c]) : '0;
      uc[c]  = (g9[c] < 4'd8) ? (QW+1)'(q9[c][0]) : (QW+1)'(q9[c][1]);
      wc[c]  = (g9[c] < 4'd4) ? (QW+1)'(q9[c][1]) : (QW+1)'(q9[c][2]);
      dc[c]  = 30'((g9[c][0] ? -uc[c] : uc[c]) + (g9[c][1] ? -wc[c] : wc[c]));
    end
  end

  // Stages 11..13: t^2, t^4, contribution.
  logic [55:0]        tt11 [4];
  logic signed [29:0] dot11 [4];
  logic [55:0]        t4p12 [4];
  logic signed [29:0] dot12 [4];
  logic signed [58:0] ct13 [4];

  // Stage 14: sum, scale and saturate.
  logic signed [60:0] sum;
  logic signed [25:0] sh;

  assign sum = 61'(ct13[0]) + 61'(ct13[1]) + 61'(ct13[2]) + 61'(ct13[3]);
  assign sh  = 26'(sum >>> 35);

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= coord_x;
      y1 <= coord_y;
      z1 <= coord_z;

      ux2 <= UW'(sx >>> F) + sn3_pkg::SK_BIAS;
      uy2 <= UW'(sy >>> F) + sn3_pkg::SK_BIAS;
      uz2 <= UW'(sz >>> F) + sn3_pkg::SK_BIAS;
      x2  <= AW'(x1);
      y2  <= AW'(y1);
      z2  <= AW'(z1);

      px3 <= (UW+N1)'(ux2) * (UW+N1)'(sn3_pkg::SK_RCP);
      py3 <= (UW+N1)'(uy2) * (UW+N1)'(sn3_pkg::SK_RCP);
      pz3 <= (UW+N1)'(uz2) * (UW+N1)'(sn3_pkg::SK_RCP);
      x3  <= x2;
      y3  <= y2;
      z3  <= z2;

      ax4 <= axc;
      ay4 <= ayc;
      az4 <= azc;
      i4  <= ci;
      j4  <= cj;
      k4  <= ck;
      o14 <= o1c;
      o24 <= o2c;

      i5  <= i4;
      j5  <= j4;
      oi5 <= oi4;
      oj5 <= oj4;
      i6  <= i5;
      oi6 <= oi5;

      for (int c = 0; c < 4; c++) begin
        hk5[c] <= hkc[c];
        hj6[c] <= hjc[c];
        g7[c]  <= gc[c];
        g8[c]  <= g7[c];
        g9[c]  <= g8[c];
        for (int d = 0; d < 3; d++) begin
          e5[c][d]  <= ec[c][d];
          ue6[c][d] <= uec[c][d];
          e6[c][d]  <= e5[c][d];
          pe7[c][d] <= (CW+N2)'(ue6[c][d]) * (CW+N2)'(sn3_pkg::CO_RCP);
          e7[c][d]  <= e6[c][d];
          q8[c][d]  <= qc[c][d];
          sq9[c][d] <= 64'(q8[c][d] * q8[c][d]);
          q9[c][d]  <= q8[c][d];
        end
        t10[c]   <= tc[c];
        dot10[c] <= dc[c];
        tt11[c]  <= 56'(t10[c]) * 56'(t10[c]);
        dot11[c] <= dot10[c];
        t4p12[c] <= 56'(tt11[c][55:28]) * 56'(tt11[c][55:28]);
        dot12[c] <= dot11[c];
        ct13[c]  <= 59'($signed({1'b0, t4p12[c][55:28]})) * 59'(dot12[c]);
      end

      // Clamp to the 18-bit output range.
      if (sh > sn3_pkg::OUT_MAX) begin
        noise_value <= 18'(sn3_pkg::OUT_MAX);
      end else if (sh < sn3_pkg::OUT_MIN) begin
        noise_value <= 18'(sn3_pkg::OUT_MIN);
      end else begin
        noise_value <= 18'(sh);
      end
    end
  end

endmodule
`default_nettype wire
